@@ rtl/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is low
`define DVFC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// clocked assertion, also checked during reset
`define DVFC_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

@@ rtl/dvfc_pkg.sv @@
// types and constants of the dipole voltage fit cost block
package dvfc_pkg;

    localparam int COORD_W  = 24;
    localparam int MAG_W    = 24;
    localparam int SQ_W     = 48;
    localparam int R2_W     = 50;
    localparam int SN_W     = 51;
    localparam int VOLT_W   = 32;
    localparam int COST_W   = 64;
    localparam int GAIN_W   = 53;
    localparam int WIDE_W   = 256;
    localparam int MPL_W    = 128;
    localparam int DEN_W    = WIDE_W + COST_W;
    localparam int QUO_W    = 64;
    localparam int SREM_W   = 34;
    localparam int STEP_W   = 7;
    localparam int SHIFT_A  = 16;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 53'd5576300000000000;
    localparam logic [STEP_W-1:0] DIV_FIRST  = 7'd64;
    localparam logic [STEP_W-1:0] SQRT_FIRST = 7'd31;

    typedef struct packed {
        logic [MAG_W-1:0]  mag_x;
        logic [MAG_W-1:0]  mag_y;
        logic [MAG_W-1:0]  mag_z;
        logic [VOLT_W-1:0] meas;
        logic              last;
    } t_item;

    typedef struct packed {
        logic              start;
        logic [WIDE_W-1:0] mcand;
        logic [MPL_W-1:0]  mplier;
    } t_mul_req;

    typedef struct packed {
        logic              done;
        logic [WIDE_W-1:0] product;
    } t_mul_rsp;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_out;

endpackage

@@ rtl/dvfc_in_if.sv @@
// input channel: one anchor word per handshake
interface dvfc_in_if import dvfc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] anchor_x;
    logic signed [COORD_W-1:0] anchor_y;
    logic signed [COORD_W-1:0] anchor_z;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic [VOLT_W-1:0]         measured_voltage;
    logic                      last_anchor;

    modport source (
        output valid, anchor_x, anchor_y, anchor_z, point_x, point_y, point_z,
               measured_voltage, last_anchor,
        input  ready
    );
    modport sink (
        input  valid, anchor_x, anchor_y, anchor_z, point_x, point_y, point_z,
               measured_voltage, last_anchor,
        output ready
    );
endinterface

@@ rtl/dvfc_out_if.sv @@
// output channel: one cost word per handshake
interface dvfc_out_if import dvfc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [COST_W-1:0] total_cost;
    logic              saturated;

    modport source (output valid, total_cost, saturated, input ready);
    modport sink (input valid, total_cost, saturated, output ready);
endinterface

@@ rtl/dvfc_front.sv @@
// front end: takes anchor words and reduces them to distance magnitudes
module dvfc_front import dvfc_pkg::*; (
    dvfc_in_if.sink i_in,
    input  logic    i_full,
    output logic    o_push,
    output t_item   o_item
);

    logic signed [COORD_W:0] dx, dy, dz;
    logic signed [COORD_W:0] nx, ny, nz;

    always_comb begin
        dx = {i_in.anchor_x[COORD_W-1], i_in.anchor_x} - {i_in.point_x[COORD_W-1], i_in.point_x};
        dy = {i_in.anchor_y[COORD_W-1], i_in.anchor_y} - {i_in.point_y[COORD_W-1], i_in.point_y};
        dz = {i_in.anchor_z[COORD_W-1], i_in.anchor_z} - {i_in.point_z[COORD_W-1], i_in.point_z};
        nx = -dx;
        ny = -dy;
        nz = -dz;
    end

    // only magnitudes matter from here on
    always_comb begin
        o_item.mag_x = dx[COORD_W] ? nx[MAG_W-1:0] : dx[MAG_W-1:0];
        o_item.mag_y = dy[COORD_W] ? ny[MAG_W-1:0] : dy[MAG_W-1:0];
        o_item.mag_z = dz[COORD_W] ? nz[MAG_W-1:0] : dz[MAG_W-1:0];
        o_item.meas  = i_in.measured_voltage;
        o_item.last  = i_in.last_anchor;
    end

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

endmodule

@@ rtl/dvfc_queue.sv @@
// two-entry queue between front and back
module dvfc_queue import dvfc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_item  i_item,
    output logic   o_full,
    input  logic   i_pop,
    output t_q_out o_q
);

    t_item      r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_item;
        end
    end

    assign o_q.valid = (r_cnt != 2'd0);
    assign o_q.item  = r_slot[r_rp];

endmodule

@@ rtl/dvfc_mul.sv @@
// shift-add multiplier, one multiplier bit per cycle, stops when the rest is zero
module dvfc_mul import dvfc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    logic              r_busy;
    logic [WIDE_W-1:0] r_acc;
    logic [WIDE_W-1:0] r_mcand;
    logic [MPL_W-1:0]  r_mplier;
    logic              finish;

    assign finish = r_busy && (r_mplier == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (!r_busy && i_req.start) begin
            r_busy <= 1'b1;
        end else if (finish) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_busy && i_req.start) begin
            r_acc    <= '0;
            r_mcand  <= i_req.mcand;
            r_mplier <= i_req.mplier;
        end else if (r_busy && !finish) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= {r_mcand[WIDE_W-2:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[MPL_W-1:1]};
        end
    end

    assign o_rsp.done    = finish;
    assign o_rsp.product = r_acc;

endmodule

@@ rtl/dvfc_back.sv @@
// back end: model voltage, squared error, running sum and result register
module dvfc_back import dvfc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [GAIN_W-1:0] i_gain,
    input  t_q_out            i_q,
    output logic              o_pop,
    output t_mul_req          o_mul,
    input  t_mul_rsp          i_mul,
    dvfc_out_if.source        o_out
);

    typedef enum logic [15:0] {
        S_IDLE = 16'h0001,
        S_SQX  = 16'h0002,
        S_SQY  = 16'h0004,
        S_SQZ  = 16'h0008,
        S_R2   = 16'h0010,
        S_NUM  = 16'h0020,
        S_MP2  = 16'h0040,
        S_MP4  = 16'h0080,
        S_MP5  = 16'h0100,
        S_MA   = 16'h0200,
        S_MA2  = 16'h0400,
        S_DIV  = 16'h0800,
        S_SQRT = 16'h1000,
        S_ERR  = 16'h2000,
        S_SQE  = 16'h4000,
        S_ACC  = 16'h8000
    } t_state;

    t_state              r_state;
    logic                r_launched;
    logic [MAG_W-1:0]    r_mx, r_my, r_mz;
    logic [VOLT_W-1:0]   r_meas;
    logic                r_last;
    logic [SQ_W-1:0]     r_sx, r_sy, r_sz;
    logic [R2_W-1:0]     r_r2;
    logic signed [SN_W-1:0] r_sn;
    logic [R2_W-1:0]     r_num;
    logic [WIDE_W-1:0]   r_p;
    logic [WIDE_W-1:0]   r_a;
    logic [DEN_W-1:0]    r_den;
    logic [WIDE_W-1:0]   r_rem;
    logic [QUO_W-1:0]    r_quo;
    logic [STEP_W-1:0]   r_step;
    logic [VOLT_W-1:0]   r_root;
    logic [SREM_W-1:0]   r_srem;
    logic                r_vsat;
    logic [VOLT_W-1:0]   r_err;
    logic [COST_W-1:0]   r_sq;
    logic [COST_W-1:0]   r_sum;
    logic                r_seen;
    logic                r_ovalid;
    logic [COST_W-1:0]   r_ocost;
    logic                r_osat;

    logic [MAG_W-1:0]    sq_op;
    logic [SQ_W-1:0]     sq_res;
    logic                in_mul;
    logic [WIDE_W-1:0]   a_shift;
    logic                div_ge;
    logic [SREM_W+1:0]   rem_sh;
    logic [SREM_W+1:0]   trial;
    logic                root_ge;
    logic [SREM_W+1:0]   rem_sub;
    logic [COST_W:0]     sum_ext;
    logic [COST_W-1:0]   n_sum;
    logic                n_seen;
    logic                out_free;

    always_comb begin
        case (r_state)
            S_SQX:   sq_op = r_mx;
            S_SQY:   sq_op = r_my;
            default: sq_op = r_mz;
        endcase
        sq_res = sq_op * sq_op;
    end

    assign in_mul  = (r_state == S_MP2) || (r_state == S_MP4) || (r_state == S_MP5)
                  || (r_state == S_MA)  || (r_state == S_MA2);
    assign a_shift = {r_a[WIDE_W-SHIFT_A-1:0], {SHIFT_A{1'b0}}};

    // operands for the five products: r2^2, r2^4, r2^5, K*num, (K*num*2^16)^2
    always_comb begin
        o_mul.start = in_mul && !r_launched;
        case (r_state)
            S_MP2: begin
                o_mul.mcand  = {{(WIDE_W-R2_W){1'b0}}, r_r2};
                o_mul.mplier = {{(MPL_W-R2_W){1'b0}}, r_r2};
            end
            S_MP4: begin
                o_mul.mcand  = r_p;
                o_mul.mplier = r_p[MPL_W-1:0];
            end
            S_MP5: begin
                o_mul.mcand  = r_p;
                o_mul.mplier = {{(MPL_W-R2_W){1'b0}}, r_r2};
            end
            S_MA: begin
                o_mul.mcand  = {{(WIDE_W-GAIN_W){1'b0}}, i_gain};
                o_mul.mplier = {{(MPL_W-R2_W){1'b0}}, r_num};
            end
            default: begin
                o_mul.mcand  = a_shift;
                o_mul.mplier = a_shift[MPL_W-1:0];
            end
        endcase
    end

    assign div_ge  = ({{(DEN_W-WIDE_W){1'b0}}, r_rem} >= r_den);
    assign rem_sh  = {r_srem, r_quo[QUO_W-1:QUO_W-2]};
    assign trial   = {2'b00, r_root, 2'b01};
    assign root_ge = (rem_sh >= trial);
    assign rem_sub = rem_sh - trial;

    always_comb begin
        sum_ext = {1'b0, r_sum} + {1'b0, r_sq};
        n_sum   = sum_ext[COST_W] ? {COST_W{1'b1}} : sum_ext[COST_W-1:0];
        n_seen  = r_seen || r_vsat || sum_ext[COST_W];
    end

    assign out_free = !r_ovalid || o_out.ready;
    assign o_pop    = (r_state == S_IDLE) && i_q.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_launched <= 1'b0;
            r_sum      <= '0;
            r_seen     <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q.valid) begin
                        r_state <= S_SQX;
                    end
                end
                S_SQX: r_state <= S_SQY;
                S_SQY: r_state <= S_SQZ;
                S_SQZ: r_state <= S_R2;
                S_R2:  r_state <= S_NUM;
                S_NUM: r_state <= S_MP2;
                S_MP2, S_MP4, S_MP5, S_MA, S_MA2: begin
                    if (!r_launched) begin
                        r_launched <= 1'b1;
                    end else if (i_mul.done) begin
                        r_launched <= 1'b0;
                        case (r_state)
                            S_MP2:   r_state <= S_MP4;
                            S_MP4:   r_state <= S_MP5;
                            S_MP5:   r_state <= S_MA;
                            S_MA:    r_state <= S_MA2;
                            default: r_state <= S_DIV;
                        endcase
                    end
                end
                S_DIV: begin
                    if (div_ge && (r_step == DIV_FIRST)) begin
                        r_state <= S_ERR;
                    end else if (r_step == '0) begin
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (r_step == '0) begin
                        r_state <= S_ERR;
                    end
                end
                S_ERR: r_state <= S_SQE;
                S_SQE: r_state <= S_ACC;
                S_ACC: begin
                    if (!r_last) begin
                        r_sum   <= n_sum;
                        r_seen  <= n_seen;
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_sum    <= '0;
                        r_seen   <= 1'b0;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_mx   <= i_q.item.mag_x;
                r_my   <= i_q.item.mag_y;
                r_mz   <= i_q.item.mag_z;
                r_meas <= i_q.item.meas;
                r_last <= i_q.item.last;
                r_vsat <= 1'b0;
            end
            S_SQX: r_sx <= sq_res;
            S_SQY: r_sy <= sq_res;
            S_SQZ: r_sz <= sq_res;
            S_R2: begin
                r_r2 <= {2'b00, r_sx} + {2'b00, r_sy} + {2'b00, r_sz};
                r_sn <= $signed({2'b00, r_sz, 1'b0}) - $signed({3'b000, r_sx})
                      - $signed({3'b000, r_sy});
            end
            S_NUM: r_num <= r_sn[SN_W-1] ? R2_W'(-r_sn) : R2_W'(r_sn);
            S_MP2, S_MP4, S_MP5: begin
                if (r_launched && i_mul.done) begin
                    r_p <= i_mul.product;
                end
            end
            S_MA, S_MA2: begin
                if (r_launched && i_mul.done) begin
                    r_a <= i_mul.product;
                end
                // set up the division of A^2 by r2^5, first step tests the 2^64 limit
                if (r_launched && i_mul.done && (r_state == S_MA2)) begin
                    r_rem  <= i_mul.product;
                    r_den  <= {r_p, {COST_W{1'b0}}};
                    r_quo  <= '0;
                    r_step <= DIV_FIRST;
                end
            end
            S_DIV: begin
                if (div_ge) begin
                    r_rem <= r_rem - r_den[WIDE_W-1:0];
                end
                r_den <= {1'b0, r_den[DEN_W-1:1]};
                r_quo <= {r_quo[QUO_W-2:0], div_ge};
                if (div_ge && (r_step == DIV_FIRST)) begin
                    // zero distance lands here too
                    r_vsat <= 1'b1;
                    r_root <= '1;
                end else if (r_step == '0) begin
                    r_step <= SQRT_FIRST;
                    r_root <= '0;
                    r_srem <= '0;
                end else begin
                    r_step <= r_step - 1'b1;
                end
            end
            S_SQRT: begin
                r_srem <= root_ge ? rem_sub[SREM_W-1:0] : rem_sh[SREM_W-1:0];
                r_root <= {r_root[VOLT_W-2:0], root_ge};
                r_quo  <= {r_quo[QUO_W-3:0], 2'b00};
                r_step <= r_step - 1'b1;
            end
            S_ERR: r_err <= (r_root >= r_meas) ? (r_root - r_meas) : (r_meas - r_root);
            S_SQE: r_sq  <= r_err * r_err;
            S_ACC: begin
                if (r_last && out_free) begin
                    r_ocost <= n_sum;
                    r_osat  <= n_seen;
                end
            end
            default: r_err <= r_err;
        endcase
    end

    assign o_out.valid      = r_ovalid;
    assign o_out.total_cost = r_ocost;
    assign o_out.saturated  = r_osat;

endmodule

@@ rtl/dipole_voltage_fit_cost.sv @@
// top level of the dipole voltage fit cost block
// Each input word carries one anchor, its measured voltage in Q16.16 and the
// candidate tag position; a word with last_anchor set closes an evaluation and
// produces one output word with the saturating Q32.32 sum of squared errors and
// a saturation flag. The front end takes a word whenever its two-entry queue has
// room, so up to two words (three with the one in the back end) are absorbed at
// full speed. The back end handles one word at a time: five products on a
// shift-add multiplier that takes one multiplier bit per cycle (r2^2, r2^4,
// r2^5, K*num, then the square of K*num*2^16), 65 restoring division steps and
// 32 square root steps. A zero distance or an oversized voltage skips the
// square root after the first division step. The gain register may be written
// only while the block is idle.
module dipole_voltage_fit_cost import dvfc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_field_gain_we,
    input  logic [GAIN_W-1:0] i_field_gain,
    dvfc_in_if.sink           i_in,
    dvfc_out_if.source        o_out
);

    logic [GAIN_W-1:0] r_field_gain;
    logic              push;
    logic              full;
    logic              pop;
    t_item             front_item;
    t_q_out            q_out;
    t_mul_req          mul_req;
    t_mul_rsp          mul_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_gain <= GAIN_RESET;
        end else if (i_field_gain_we) begin
            r_field_gain <= i_field_gain;
        end
    end

    dvfc_front u_front (
        .i_in   (i_in),
        .i_full (full),
        .o_push (push),
        .o_item (front_item)
    );

    dvfc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_q     (q_out)
    );

    dvfc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    dvfc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_gain  (r_field_gain),
        .i_q     (q_out),
        .o_pop   (pop),
        .o_mul   (mul_req),
        .i_mul   (mul_rsp),
        .o_out   (o_out)
    );

endmodule

@@ rtl/dvfc_checker.sv @@
// port-level checks of the dipole voltage fit cost block and their binding
`include "assert_macros.svh"

module dvfc_checker import dvfc_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [COST_W-1:0] i_total_cost,
    input logic              i_saturated
);

    // a stalled result word keeps its valid and its contents
    `DVFC_ASSERT(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_total_cost) && $stable(i_saturated)))

    // reset drops any pending result
    `DVFC_ASSERT_RST(a_rst_out, i_clk, !i_rst_n |=> !i_out_valid)

    // reset empties the queue so the input side is open again
    `DVFC_ASSERT_RST(a_rst_ready, i_clk, !i_rst_n |=> i_in_ready)

    // a result word on offer carries defined contents
    `DVFC_ASSERT(a_out_known, i_clk, i_rst_n, i_out_valid |-> !$isunknown({i_total_cost, i_saturated}))

endmodule

bind dipole_voltage_fit_cost dvfc_checker u_dvfc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_total_cost (o_out.total_cost),
    .i_saturated  (o_out.saturated)
);

@@ tb/tb_dipole_voltage_fit_cost.sv @@
// testbench for the dipole voltage fit cost block: directed table, then random anchor sets
module tb_dipole_voltage_fit_cost import dvfc_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [COORD_W-1:0] ax, ay, az, px, py, pz;
        logic [VOLT_W-1:0]         meas;
        logic                      last;
        logic                      chk;    // typed-in result present
        logic [COST_W-1:0]         cost;
        logic                      sat;
    } t_row;

    typedef struct {
        logic [COST_W-1:0] cost;
        logic              sat;
    } t_cost;

    localparam logic [GAIN_W-1:0] GAIN_MAX = {GAIN_W{1'b1}};
    localparam logic [COORD_W-1:0] CMAX = 24'h7FFFFF;
    localparam logic [COORD_W-1:0] CMIN = 24'h800000;
    localparam int LIMIT = 3_000_000;
    localparam int DRAIN = 600;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_field_gain_we = 1'b0;
    logic [GAIN_W-1:0] i_field_gain = '0;

    dvfc_in_if  in_ch ();
    dvfc_out_if out_ch ();

    dipole_voltage_fit_cost i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_field_gain_we (i_field_gain_we),
        .i_field_gain    (i_field_gain),
        .i_in            (in_ch.sink),
        .o_out           (out_ch.source)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state
    logic [GAIN_W-1:0] gain_q;
    logic [COST_W-1:0] sum_q;
    logic              sat_q;
    t_cost             cost_fifo[$];
    t_row              rows[$];
    int                errors = 0;
    int                cycles = 0;
    bit                idle_off = 1'b0;
    bit                hold_off = 1'b0;

    // floor(K*num*2^16 / r^5) with saturation, exact via integer square root
    function automatic logic [VOLT_W-1:0] dipole_volts(
        logic signed [COORD_W:0] dx, dy, dz, logic [GAIN_W-1:0] k, output logic sat);
        logic [63:0]  sx, sy, sz, r2, num;
        logic signed [63:0] sn;
        logic [511:0] p, q, t;
        logic [31:0]  v, c;
        sat = 1'b0;
        sx = 64'(dx * dx);
        sy = 64'(dy * dy);
        sz = 64'(dz * dz);
        r2 = sx + sy + sz;
        sn = $signed(2 * sz) - $signed(sx) - $signed(sy);
        num = sn < 0 ? 64'(-sn) : 64'(sn);
        if (r2 == 0) begin
            sat = 1'b1;
            return '1;
        end
        p = 512'(r2) * r2 * r2 * r2 * r2;
        t = 512'(k) * (512'(num) << 16);
        q = t * t;
        if ((p << 64) <= q) begin
            sat = 1'b1;
            return '1;
        end
        v = '0;
        for (int b = 31; b >= 0; b--) begin
            c = v | (32'd1 << b);
            if (512'(c) * c * p <= q) v = c;
        end
        return v;
    endfunction

    task automatic predict_cost(input t_row r);
        logic [VOLT_W-1:0] v;
        logic [63:0] e, sq;
        logic s;
        t_cost res;
        v = dipole_volts(25'(r.ax) - 25'(r.px), 25'(r.ay) - 25'(r.py),
                         25'(r.az) - 25'(r.pz), gain_q, s);
        e = v >= r.meas ? 64'(v - r.meas) : 64'(r.meas - v);
        sq = e * e;
        if (s) sat_q = 1'b1;
        if (sum_q > ~sq) begin
            sum_q = '1;
            sat_q = 1'b1;
        end else begin
            sum_q = sum_q + sq;
        end
        if (r.last) begin
            res.cost = sum_q;
            res.sat = sat_q;
            if (r.chk && (res.cost !== r.cost || res.sat !== r.sat)) begin
                $error("table row: expected cost %h sat %b, predicted %h %b",
                    r.cost, r.sat, res.cost, res.sat);
                errors++;
            end
            cost_fifo.push_back(res);
            sum_q = '0;
            sat_q = 1'b0;
        end
    endtask

    function automatic t_row mk(logic [23:0] ax, ay, az, px, py, pz,
                                logic [31:0] m, logic l);
        t_row r;
        r = '{ax, ay, az, px, py, pz, m, l, 1'b0, '0, 1'b0};
        return r;
    endfunction

    function automatic t_row mk_chk(logic [23:0] ax, az, pz, logic [31:0] m,
                                    logic [63:0] cst, logic s);
        t_row r;
        r = '{ax, 24'd0, az, 24'd0, 24'd0, pz, m, 1'b1, 1'b1, cst, s};
        return r;
    endfunction

    function automatic logic [23:0] rnd_coord();
        case ($urandom_range(0, 5))
            0: return 24'($urandom);
            1: return CMAX;
            2: return CMIN;
            default: return 24'($signed(24'($urandom_range(0, 4000))) - 24'sd2000);
        endcase
    endfunction

    function automatic t_row rnd_row(logic l);
        t_row r;
        logic [23:0] px, py, pz;
        px = rnd_coord();
        py = rnd_coord();
        pz = rnd_coord();
        r = mk(rnd_coord(), rnd_coord(), rnd_coord(), px, py, pz, $urandom, l);
        if ($urandom_range(0, 19) == 0) begin
            r.ax = px; r.ay = py; r.az = pz;
        end else if ($urandom_range(0, 3) == 0) begin
            // near field: anchor within +-300 of the tag position on each axis
            r.ax = px + 24'($urandom_range(0, 600)) - 24'd300;
            r.ay = py + 24'($urandom_range(0, 600)) - 24'd300;
            r.az = pz + 24'($urandom_range(0, 600)) - 24'd300;
        end
        case ($urandom_range(0, 3))
            0: r.meas = '0;
            1: r.meas = '1;
            default: ;
        endcase
        return r;
    endfunction

    task automatic set_gain(input logic [GAIN_W-1:0] k);
        @(posedge i_clk);
        i_field_gain_we <= 1'b1;
        i_field_gain <= k;
        @(posedge i_clk);
        i_field_gain_we <= 1'b0;
        gain_q = k;
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (cost_fifo.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic send_word(input t_row r);
        if ($urandom_range(0, 99) < 24 && !idle_off) begin
            in_ch.valid <= 1'b0;
            do begin
                @(posedge i_clk);
            end while ($urandom_range(0, 99) < 24);
        end
        in_ch.valid <= 1'b1;
        in_ch.anchor_x <= r.ax;
        in_ch.anchor_y <= r.ay;
        in_ch.anchor_z <= r.az;
        in_ch.point_x <= r.px;
        in_ch.point_y <= r.py;
        in_ch.point_z <= r.pz;
        in_ch.measured_voltage <= r.meas;
        in_ch.last_anchor <= r.last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_cost(r);
    endtask

    task automatic send_set(input int n);
        for (int j = 0; j < n; j++) send_word(rnd_row(j == n - 1));
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.anchor_x = '0;
        in_ch.anchor_y = '0;
        in_ch.anchor_z = '0;
        in_ch.point_x = '0;
        in_ch.point_y = '0;
        in_ch.point_z = '0;
        in_ch.measured_voltage = '0;
        in_ch.last_anchor = 1'b0;
        gain_q = GAIN_RESET;
        sum_q = '0;
        sat_q = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero distance saturates whatever the measurement
        rows.push_back(mk_chk(24'd0, 24'd0, 24'd0, 32'hFFFFFFFF, 64'd0, 1'b1));
        rows.push_back(mk_chk(24'd0, 24'd0, 24'd0, 32'd0, 64'hFFFFFFFE00000001, 1'b1));
        // huge voltage at one micrometre
        rows.push_back(mk_chk(24'd0, 24'd1, 24'd0, 32'd5, 64'hFFFFFFF400000024, 1'b1));
        // extremes of the position range
        rows.push_back(mk(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 32'hFFFFFFFF, 1'b0));
        rows.push_back(mk(CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, 32'h0, 1'b1));
        rows.push_back(mk(CMAX, 24'd0, 24'd0, CMIN, 24'd0, 24'd0, 32'h12345678, 1'b1));
        // anchors off the 3dz^2 = r^2 cone, then alternating bit patterns
        rows.push_back(mk(24'd1000, 24'd1000, 24'd2000, 24'd0, 24'd0, 24'd0, 32'h1, 1'b1));
        rows.push_back(mk(24'h000AAA, 24'h555555, 24'hAAAAAA, 24'h0, 24'h0, 24'h0,
                          32'h55555555, 1'b0));
        rows.push_back(mk(24'hFFF555, 24'hAAAAAA, 24'h555555, 24'h0, 24'h0, 24'h0,
                          32'hAAAAAAAA, 1'b1));
        // sum overflow over several saturated anchors
        for (int j = 0; j < 4; j++)
            rows.push_back(mk(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 32'd0, j == 3));
        foreach (rows[j]) send_word(rows[j]);

        wait_idle();
        set_gain('0);
        send_set(3);
        wait_idle();
        set_gain(GAIN_MAX);
        send_set(3);
        wait_idle();
        set_gain(53'd1000);

        // long run without idling; the receiver holds off once partway through
        idle_off = 1'b1;
        for (int n = 0; n < 200; ) begin
            int k;
            k = $urandom_range(1, 4);
            if (n <= 20 && n + k > 20) hold_off = 1'b1;
            send_set(k);
            n += k;
        end
        idle_off = 1'b0;
        wait_idle();
        set_gain(GAIN_RESET);
        for (int n = 0; n < 380; ) begin
            int k;
            k = $urandom_range(1, 5);
            send_set(k);
            n += k;
        end
        // a trailing word without last anchor, then one that closes the set
        send_set(2);
        wait_idle();
        if (errors == 0) begin
            $display("dipole_voltage_fit_cost: match");
        end else begin
            $display("dipole_voltage_fit_cost: mismatch");
        end
        $finish;
    end

    // receiver with random stalls and one long hold-off
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                out_ch.ready <= 1'b0;
                repeat (3000) @(posedge i_clk);
                hold_off = 1'b0;
            end
            out_ch.ready <= idle_off ? 1'b1 : ($urandom_range(0, 99) >= 24);
        end
    end

    always @(posedge i_clk) begin
        t_cost e;
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("dipole_voltage_fit_cost: mismatch");
            $finish;
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (cost_fifo.size() == 0) begin
                $error("unexpected cost word %h", out_ch.total_cost);
                errors++;
            end else begin
                e = cost_fifo.pop_front();
                if (out_ch.total_cost !== e.cost) begin
                    $error("total_cost expected %h actual %h", e.cost, out_ch.total_cost);
                    errors++;
                end
                if (out_ch.saturated !== e.sat) begin
                    $error("saturated expected %b actual %b", e.sat, out_ch.saturated);
                    errors++;
                end
            end
        end
    end
endmodule
